>>> hw/rtl/baseline_peak_event_trigger_top_assert.svh
// Assertion macros for the trigger top level.
// Each expects clk and rst_n in scope.
`ifndef BASELINE_PEAK_EVENT_TRIGGER_TOP_ASSERT_SVH
`define BASELINE_PEAK_EVENT_TRIGGER_TOP_ASSERT_SVH

// same-cycle implication
`define BPET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bpet_pkg.sv
`default_nettype none

package bpet_pkg;

  // input field widths
  localparam int CH_W     = 10;
  localparam int SAMPLE_W = 12;
  localparam int TRIG_W   = 12;

  // in_tdata layout, lowest bit first
  localparam int CH_LSB    = 0;
  localparam int SMP_LSB   = CH_LSB + CH_W;
  localparam int TRG_LSB   = SMP_LSB + SAMPLE_W;
  localparam int IN_DATA_W = 40;

  localparam int OUT_DATA_W = 8;

  // threshold register, 1/16 count
  localparam int                 THR_W     = 16;
  localparam logic [THR_W-1:0]   THR_RESET = 16'd960;

  // what travels down the verdict pipe
  typedef enum logic {
    KIND_TEST = 1'b0,   // end of waveform, amplitude test
    KIND_MARK = 1'b1    // end of event, report and clear
  } kind_t;

endpackage

`default_nettype wire

>>> hw/rtl/baseline_peak_event_trigger_top.sv
// Channel  | Ports                                  | Transaction
// ---------+----------------------------------------+-------------------------------
// input    | in_tvalid/in_tready/in_tdata/in_tuser/ | one sample or end-of-event
//          | in_tlast                               | marker
// result   | out_tvalid/out_tready/out_tdata        | keep/drop verdict per marker
// config   | cfg_we/cfg_wdata                       | threshold write, 1/16 count
//
// One transaction per clock unless back-pressure holds; a verdict shows on out_tvalid
// after its marker passes input register, accumulator, multiply stage, output register.
// Synchronous active-low reset clears the waveform state, the hit flag and all
// valid flags, and loads the threshold with 60.0 counts.
// Back-pressure builds only when an untaken verdict meets another marker at the
// multiply stage; bubbles in front of it still fill.
`default_nettype none

module baseline_peak_event_trigger_top #(
  parameter int SAMPLE_BITS     = 12,
  parameter int MAX_SAMPLES     = 2048,
  parameter int WIRES_PER_PLANE = 38,
  parameter int PLANES          = 6,
  parameter int PRETRACE_GAP    = 25,
  parameter int BASELINE_LEN    = 500
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // [9:0] channel, [21:10] sample, [33:22] trigger_offset, rest zero
  input  wire logic [bpet_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] mode
  input  wire logic                           in_tuser,
  input  wire logic                           in_tlast,      // last_sample
  // result channel
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] keep_event, rest zero
  output      logic [bpet_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [bpet_pkg::THR_W-1:0]     cfg_wdata
);

  // effective sample width after masking
  localparam int EFF_W  = (SAMPLE_BITS < bpet_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                             : bpet_pkg::SAMPLE_W;
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int LEN_W  = $clog2(BASELINE_LEN + 1);
  // Sum saturates sticky once its top bit sets: from there on the amplitude
  // test is certainly passed, as the sum then exceeds n * 8192.
  localparam int SUM_W  = LEN_W + 14;
  localparam int CMP_W  = bpet_pkg::TRIG_W + 1;
  localparam int CHC_W  = bpet_pkg::CH_W + 1;
  localparam int MN_W   = EFF_W + LEN_W;
  localparam int TN_W   = bpet_pkg::THR_W + LEN_W;
  localparam int DIF_W  = SUM_W + 1;
  localparam int BEY_W  = bpet_pkg::THR_W + 1;
  localparam int MP1_W  = BEY_W - 4;
  localparam int GAP_LEN = PRETRACE_GAP + BASELINE_LEN;

  // ---------------- configuration ----------------
  logic [bpet_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= bpet_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // ---------------- handshake chain ----------------
  logic           v1_r, v2_r, v3_r;
  bpet_pkg::kind_t kind2_r, kind3_r;
  logic           out_valid_r;
  logic           out_keep_r;
  logic           out_free, go3, en3, en2, en1, fire3, take1, take_in;

  assign out_free = !out_valid_r || out_tready;
  // test items never need the output slot
  assign go3      = (kind3_r == bpet_pkg::KIND_TEST) || out_free;
  assign en3      = !v3_r || go3;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign fire3    = v3_r && go3;
  assign take1    = v1_r && en2;
  assign in_tready = en1;
  assign take_in  = in_tvalid && en1;

  // ---------------- stage 1: decode and register input ----------------
  logic [bpet_pkg::CH_W-1:0]     ch_in;
  logic [bpet_pkg::TRIG_W-1:0]   t_in, beg_in, end_in, n_full;
  logic                          used_in;

  logic                          mode1_r, used1_r, last1_r;
  logic [EFF_W-1:0]              s1_r;
  logic [bpet_pkg::TRIG_W-1:0]   t1_r, beg1_r, end1_r;
  logic [LEN_W-1:0]              n1_r;

  assign ch_in = in_tdata[bpet_pkg::CH_LSB +: bpet_pkg::CH_W];
  assign t_in  = in_tdata[bpet_pkg::TRG_LSB +: bpet_pkg::TRIG_W];

  // even planes only; negative channels drop out
  always_comb begin
    logic [CHC_W-1:0] chu;
    chu     = {1'b0, ch_in};
    used_in = 1'b0;
    for (int k = 0; k < PLANES; k += 2) begin
      if (!ch_in[bpet_pkg::CH_W-1] &&
          chu >= CHC_W'(k * WIRES_PER_PLANE) &&
          chu <  CHC_W'((k + 1) * WIRES_PER_PLANE)) begin
        used_in = 1'b1;
      end
    end
  end

  // baseline window [beg, end)
  assign beg_in = (t_in > bpet_pkg::TRIG_W'(GAP_LEN)) ?
                  t_in - bpet_pkg::TRIG_W'(GAP_LEN) : '0;
  assign end_in = (t_in > bpet_pkg::TRIG_W'(PRETRACE_GAP + 1)) ?
                  t_in - bpet_pkg::TRIG_W'(PRETRACE_GAP) : bpet_pkg::TRIG_W'(1);
  assign n_full = end_in - beg_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      mode1_r <= in_tuser;
      used1_r <= used_in;
      last1_r <= in_tlast;
      s1_r    <= in_tdata[bpet_pkg::SMP_LSB +: EFF_W];
      t1_r    <= t_in;
      beg1_r  <= beg_in;
      end1_r  <= end_in;
      n1_r    <= n_full[LEN_W-1:0];
    end
  end

  // ---------------- stage 2: waveform accumulator ----------------
  logic [IDX_W-1:0] sample_index_r, sample_index_nxt;
  logic [EFF_W-1:0] running_max_r, running_max_nxt, max_new;
  logic [SUM_W-1:0] window_sum_r, window_sum_nxt, sum_new;
  logic [CMP_W-1:0] pe;
  logic             in_win, pass2;

  logic [EFF_W-1:0] max2_r;
  logic [SUM_W-1:0] sum2_r;
  logic [LEN_W-1:0] n2_r;
  logic             beyond2_r;

  assign pe      = CMP_W'(sample_index_r);
  assign max_new = (sample_index_r == '0 || s1_r > running_max_r) ? s1_r : running_max_r;
  assign in_win  = (pe >= CMP_W'(beg1_r)) && (pe < CMP_W'(end1_r));
  assign sum_new = (!in_win || window_sum_r[SUM_W-1]) ? window_sum_r
                                                      : window_sum_r + SUM_W'(s1_r);
  // items that go on to the verdict pipe
  assign pass2   = mode1_r || (used1_r && last1_r);

  always_comb begin
    sample_index_nxt = sample_index_r;
    running_max_nxt  = running_max_r;
    window_sum_nxt   = window_sum_r;
    if (take1) begin
      if (mode1_r || (used1_r && last1_r)) begin
        sample_index_nxt = '0;
        running_max_nxt  = '0;
        window_sum_nxt   = '0;
      end else if (used1_r) begin
        running_max_nxt = max_new;
        window_sum_nxt  = sum_new;
        if (sample_index_r < IDX_W'(MAX_SAMPLES - 1)) begin
          sample_index_nxt = sample_index_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      running_max_r  <= '0;
      window_sum_r   <= '0;
      v2_r           <= 1'b0;
    end else begin
      sample_index_r <= sample_index_nxt;
      running_max_r  <= running_max_nxt;
      window_sum_r   <= window_sum_nxt;
      if (en2) begin
        v2_r <= take1 && pass2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && pass2) begin
      kind2_r   <= mode1_r ? bpet_pkg::KIND_MARK : bpet_pkg::KIND_TEST;
      max2_r    <= max_new;
      sum2_r    <= sum_new;
      n2_r      <= n1_r;
      // trigger beyond waveform length (index + 1)
      beyond2_r <= CMP_W'(t1_r) > (pe + 1'b1);
    end
  end

  // ---------------- stage 3: products ----------------
  logic [MN_W-1:0]  mn2;
  logic [TN_W-1:0]  tn2;
  logic [MN_W-1:0]  mn3_r;
  logic [TN_W-1:0]  tn3_r;
  logic [EFF_W-1:0] max3_r;
  logic [SUM_W-1:0] sum3_r;
  logic             beyond3_r;

  assign mn2 = MN_W'(max2_r) * MN_W'(n2_r);
  assign tn2 = TN_W'(thr_r) * TN_W'(n2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      kind3_r   <= kind2_r;
      mn3_r     <= mn2;
      tn3_r     <= tn2;
      max3_r    <= max2_r;
      sum3_r    <= sum2_r;
      beyond3_r <= beyond2_r;
    end
  end

  // ---------------- stage 4: verdict, hit flag, output register ----------------
  logic signed [DIF_W-1:0] diff;
  logic [SUM_W-1:0]        mag;
  logic [MP1_W-1:0]        max_p1;
  logic                    above;
  logic                    event_hit_r, event_hit_nxt;
  logic                    out_valid_nxt;

  assign diff   = $signed(DIF_W'(mn3_r)) - $signed(DIF_W'(sum3_r[SUM_W-2:0]));
  assign mag    = diff[DIF_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
  assign max_p1 = MP1_W'(max3_r) + 1'b1;

  always_comb begin
    if (beyond3_r) begin
      above = {max_p1, 4'b0000} > BEY_W'(thr_r);   // baseline taken as -1
    end else if (sum3_r[SUM_W-1]) begin
      above = 1'b1;
    end else begin
      above = {mag, 4'b0000} > (SUM_W + 4)'(tn3_r);
    end
  end

  always_comb begin
    event_hit_nxt = event_hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (fire3) begin
      if (kind3_r == bpet_pkg::KIND_MARK) begin
        event_hit_nxt = 1'b0;
        out_valid_nxt = 1'b1;
      end else if (above) begin
        event_hit_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      event_hit_r <= event_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire3 && kind3_r == bpet_pkg::KIND_MARK) begin
      out_keep_r <= event_hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bpet_pkg::OUT_DATA_W'(out_keep_r);

  // ---------------- assertions ----------------
`include "baseline_peak_event_trigger_top_assert.svh"

  `BPET_ASSERT_NEXT(a_mark_clears_hit, fire3 && kind3_r == bpet_pkg::KIND_MARK, !event_hit_r, "hit flag survived an end-of-event marker")
  `BPET_ASSERT_NEXT(a_mark_gives_result, fire3 && kind3_r == bpet_pkg::KIND_MARK, out_valid_r, "end-of-event marker gave no verdict")
  `BPET_ASSERT_NEXT(a_marker_clears_wave, take1 && mode1_r, sample_index_r == '0 && running_max_r == '0 && window_sum_r == '0, "waveform state not cleared by marker")
  `BPET_ASSERT_NOW(a_index_saturates, v1_r || !v1_r, sample_index_r <= IDX_W'(MAX_SAMPLES - 1), "sample index past saturation")

endmodule

`default_nettype wire
